// File: rtl/ttip_pkg.sv
// Package for the text to integer parser: shared types, codes and constants.
// Used by every module of the block; depends on nothing.
`default_nettype none

package ttip_pkg;

  localparam logic [15:0] CNT_LIMIT = 16'hFFFF;
  localparam int          QDEPTH    = 4;
  localparam int          QAW       = $clog2(QDEPTH);

  localparam logic [5:0] BASE_DEC   = 6'd10;
  localparam logic [5:0] BASE_OCT   = 6'd8;
  localparam logic [5:0] BASE_HEX   = 6'd16;
  localparam logic [5:0] BASE_AUTO  = 6'd0;
  localparam logic [5:0] BASE_ONE   = 6'd1;
  localparam logic [5:0] BASE_MAX   = 6'd36;
  localparam logic [5:0] DIG_NONE   = 6'd36;
  localparam logic [5:0] DIG_ZERO   = 6'd0;
  localparam logic [5:0] DIG_X      = 6'd33;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_D0    = 8'h30;
  localparam logic [7:0] CH_D9    = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;

  localparam logic [1:0] MODE_S32 = 2'd0;
  localparam logic [1:0] MODE_S64 = 2'd1;
  localparam logic [1:0] MODE_U32 = 2'd2;
  localparam logic [1:0] MODE_U64 = 2'd3;

  localparam logic [0:0] REG_BASE = 1'b0;
  localparam logic [0:0] REG_MODE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NODIG   = 2'd1,
    ST_RANGE   = 2'd2,
    ST_BADBASE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_SPACE   = 3'd0,
    PH_SIGN    = 3'd1,
    PH_ZERO    = 3'd2,
    PH_HEXPFX  = 3'd3,
    PH_DIGITS  = 3'd4,
    PH_DONE    = 3'd5,
    PH_BADBASE = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_SIGN    = 3'd1,
    ACT_ZERO    = 3'd2,
    ACT_HEX     = 3'd3,
    ACT_TRY_DEC = 3'd4,
    ACT_TRY_OCT = 3'd5
  } action_t;

  typedef struct packed {
    logic [5:0] digit;
    logic       is_space;
    logic       is_sign;
    logic       is_minus;
    logic       is_last;
  } item_t;

  typedef struct packed {
    logic [63:0] acc;
    logic        neg;
    logic        ovf;
    logic        dig;
    logic        badbase;
    logic [15:0] end_pos;
    logic [1:0]  mode;
  } fin_t;

endpackage

`default_nettype wire

// File: rtl/ttip_front.sv
// Front of the parser: classifies each incoming character into a queue word.
// Depends on ttip_pkg.
`default_nettype none

module ttip_front import ttip_pkg::*; (
  input  wire logic [7:0] text_char,
  input  wire logic       is_last,
  output item_t           item
);

  logic [5:0] digit_w;

  always_comb begin
    if (text_char >= CH_D0 && text_char <= CH_D9) begin
      digit_w = 6'(text_char - CH_D0);
    end else if (text_char >= CH_LA && text_char <= CH_LZ) begin
      digit_w = 6'(text_char - CH_LA) + BASE_DEC;
    end else if (text_char >= CH_UA && text_char <= CH_UZ) begin
      digit_w = 6'(text_char - CH_UA) + BASE_DEC;
    end else begin
      digit_w = DIG_NONE;
    end
  end

  always_comb begin
    item.digit    = digit_w;
    item.is_space = (text_char == CH_SPACE) || (text_char >= CH_TAB && text_char <= CH_CR);
    item.is_sign  = (text_char == CH_PLUS) || (text_char == CH_MINUS);
    item.is_minus = (text_char == CH_MINUS);
    item.is_last  = is_last;
  end

endmodule

`default_nettype wire

// File: rtl/ttip_queue.sv
// Short queue of classified words between the front and the back.
// Depends on ttip_pkg.
`default_nettype none

module ttip_queue import ttip_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire item_t push_item,
  output logic       full,
  input  wire logic  pop,
  output logic       head_valid,
  output item_t      head_item
);

  item_t          mem_r [QDEPTH];
  logic [QAW-1:0] wptr_r, rptr_r;
  logic [QAW:0]   cnt_r, cnt_nxt;

  assign full       = (cnt_r == (QAW+1)'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_item  = mem_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ttip_back.sv
// Back of the parser: walks the parse phases one word per cycle, holding the last word
// until the result stage is ready to take the finished-number snapshot. Depends on ttip_pkg.
`default_nettype none

module ttip_back import ttip_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [5:0] cfg_base,
  input  wire logic [1:0] cfg_mode,
  input  wire logic       head_valid,
  input  wire item_t      head_item,
  output logic            pop,
  input  wire logic       fin_ready,
  output logic            fin_push,
  output fin_t            fin
);

  phase_t      phase_r, phase_nxt, phase_cur;
  logic [63:0] acc_r, acc_nxt;
  logic        neg_r, neg_nxt;
  logic [5:0]  base_r, base_nxt, base_cur, tbase;
  logic [15:0] pos_r, end_r, end_nxt, next_pos;
  logic        ovf_r, ovf_nxt;
  logic        dig_r, dig_nxt;
  action_t     act;
  logic        digit_ok, is_try, first;
  logic [69:0] mac_w;

  assign pop      = head_valid && (!head_item.is_last || fin_ready);
  assign fin_push = pop && head_item.is_last;

  assign first    = (pos_r == '0);
  assign next_pos = (pos_r < CNT_LIMIT) ? pos_r + 16'd1 : CNT_LIMIT;
  assign base_cur = first ? cfg_base : base_r;

  always_comb begin
    if (first && (cfg_base == BASE_ONE || cfg_base > BASE_MAX)) begin
      phase_cur = PH_BADBASE;
    end else begin
      phase_cur = phase_r;
    end
  end

  always_comb begin
    unique case (phase_cur) inside
      PH_SPACE: begin
        if (head_item.is_space) begin
          act = ACT_NONE;
        end else if (head_item.is_sign) begin
          act = ACT_SIGN;
        end else if (head_item.digit == DIG_ZERO && (base_cur == BASE_AUTO ||
                     base_cur == BASE_OCT || base_cur == BASE_HEX)) begin
          act = ACT_ZERO;
        end else begin
          act = ACT_TRY_DEC;
        end
      end
      PH_SIGN: begin
        if (head_item.digit == DIG_ZERO && (base_cur == BASE_AUTO ||
            base_cur == BASE_OCT || base_cur == BASE_HEX)) begin
          act = ACT_ZERO;
        end else begin
          act = ACT_TRY_DEC;
        end
      end
      PH_ZERO: begin
        if ((base_cur == BASE_AUTO || base_cur == BASE_HEX) && head_item.digit == DIG_X) begin
          act = ACT_HEX;
        end else begin
          act = ACT_TRY_OCT;
        end
      end
      PH_HEXPFX, PH_DIGITS: begin
        act = ACT_TRY_DEC;
      end
      default: begin
        act = ACT_NONE;
      end
    endcase
  end

  assign is_try = (act == ACT_TRY_DEC) || (act == ACT_TRY_OCT);

  always_comb begin
    if (base_cur != BASE_AUTO) begin
      tbase = base_cur;
    end else if (act == ACT_TRY_OCT) begin
      tbase = BASE_OCT;
    end else begin
      tbase = BASE_DEC;
    end
  end

  assign digit_ok = head_item.digit < tbase;
  assign mac_w    = 70'(acc_r) * 70'(tbase) + 70'(head_item.digit);

  always_comb begin
    unique case (act)
      ACT_SIGN:    phase_nxt = PH_SIGN;
      ACT_ZERO:    phase_nxt = PH_ZERO;
      ACT_HEX:     phase_nxt = PH_HEXPFX;
      ACT_TRY_DEC,
      ACT_TRY_OCT: phase_nxt = digit_ok ? PH_DIGITS : PH_DONE;
      default:     phase_nxt = phase_cur;
    endcase
  end

  always_comb begin
    acc_nxt  = acc_r;
    neg_nxt  = neg_r;
    base_nxt = base_cur;
    end_nxt  = end_r;
    ovf_nxt  = ovf_r;
    dig_nxt  = dig_r;
    if (act == ACT_SIGN) begin
      neg_nxt = head_item.is_minus;
    end
    if (act == ACT_ZERO) begin
      dig_nxt = 1'b1;
      acc_nxt = '0;
      end_nxt = next_pos;
    end
    if (act == ACT_HEX) begin
      base_nxt = BASE_HEX;
    end
    if (is_try) begin
      base_nxt = tbase;
      if (digit_ok) begin
        dig_nxt = 1'b1;
        end_nxt = next_pos;
        if (!ovf_r) begin
          if (mac_w[69:64] != '0) begin
            ovf_nxt = 1'b1;
            acc_nxt = '1;
          end else begin
            acc_nxt = mac_w[63:0];
          end
        end
      end
    end
  end

  always_comb begin
    fin.acc     = acc_nxt;
    fin.neg     = neg_nxt;
    fin.ovf     = ovf_nxt;
    fin.dig     = dig_nxt;
    fin.badbase = (phase_nxt == PH_BADBASE);
    fin.end_pos = end_nxt;
    fin.mode    = cfg_mode;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SPACE;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      base_r  <= '0;
      pos_r   <= '0;
      end_r   <= '0;
      ovf_r   <= 1'b0;
      dig_r   <= 1'b0;
    end else if (pop) begin
      if (head_item.is_last) begin
        phase_r <= PH_SPACE;
        acc_r   <= '0;
        neg_r   <= 1'b0;
        base_r  <= '0;
        pos_r   <= '0;
        end_r   <= '0;
        ovf_r   <= 1'b0;
        dig_r   <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        neg_r   <= neg_nxt;
        base_r  <= base_nxt;
        pos_r   <= next_pos;
        end_r   <= end_nxt;
        ovf_r   <= ovf_nxt;
        dig_r   <= dig_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/ttip_result.sv
// Result stage: holds the finished-number snapshot, converts it to the
// selected mode with saturation and drives the output register. Depends on ttip_pkg.
`default_nettype none

module ttip_result import ttip_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   fin_push,
  input  wire fin_t   fin,
  output logic        fin_ready,
  output logic        out_valid,
  input  wire logic   out_stall,
  output logic [63:0] out_value_bits,
  output logic [15:0] out_chars_consumed,
  output logic [1:0]  out_status
);

  logic        fin_valid_r;
  fin_t        fin_r;
  logic        out_valid_r, out_load;
  logic [63:0] val_r, val_nxt, lim, neg_acc;
  logic [15:0] cnt_r, cnt_nxt;
  status_t     st_r, st_nxt;

  assign out_load  = fin_valid_r && (!out_valid_r || !out_stall);
  assign fin_ready = !fin_valid_r || out_load;

  assign neg_acc = 64'd0 - fin_r.acc;

  always_comb begin
    if (fin_r.mode == MODE_S32) begin
      lim = 64'h0000_0000_7FFF_FFFF;
    end else if (fin_r.mode == MODE_S64) begin
      lim = 64'h7FFF_FFFF_FFFF_FFFF;
    end else if (fin_r.mode == MODE_U32) begin
      lim = 64'h0000_0000_FFFF_FFFF;
    end else begin
      lim = '1;
    end
  end

  always_comb begin
    val_nxt = '0;
    cnt_nxt = '0;
    st_nxt  = ST_OK;
    if (fin_r.badbase) begin
      st_nxt = ST_BADBASE;
    end else if (!fin_r.dig) begin
      st_nxt = ST_NODIG;
    end else begin
      cnt_nxt = fin_r.end_pos;
      if (fin_r.mode == MODE_S32 || fin_r.mode == MODE_S64) begin
        if (!fin_r.neg) begin
          if (!fin_r.ovf && fin_r.acc <= lim) begin
            val_nxt = fin_r.acc;
          end else begin
            val_nxt = lim;
            st_nxt  = ST_RANGE;
          end
        end else begin
          if (!fin_r.ovf && fin_r.acc <= lim + 64'd1) begin
            val_nxt = neg_acc;
          end else begin
            val_nxt = ~lim;
            st_nxt  = ST_RANGE;
          end
        end
      end else begin
        if (fin_r.ovf || fin_r.acc > lim) begin
          val_nxt = lim;
          st_nxt  = ST_RANGE;
        end else begin
          val_nxt = (fin_r.neg ? neg_acc : fin_r.acc) & lim;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (fin_push) begin
        fin_valid_r <= 1'b1;
      end else if (out_load) begin
        fin_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_push) begin
      fin_r <= fin;
    end
    if (out_load) begin
      val_r <= val_nxt;
      cnt_r <= cnt_nxt;
      st_r  <= st_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_value_bits     = val_r;
  assign out_chars_consumed = cnt_r;
  assign out_status         = st_r;

endmodule

`default_nettype wire

// File: rtl/text_to_integer_parser.sv
// Top level of the text to integer parser: configuration registers and the
// front, queue, back and result stages. Depends on ttip_pkg and all ttip_ modules.
//
// A string arrives one character per word on the in_ channel; the word with
// in_is_last set closes it and causes exactly one result word on the out_
// channel (value, characters consumed, status). Both channels use valid and
// stall: a word moves at a clock edge where valid is high and stall is low.
// Throughput is one character per cycle while in_stall is low; the back stage does one
// multiply by the radix and add per cycle. The last character passes through the queue,
// the snapshot register of the result stage and the output register before out_valid
// rises. The APB port sets the radix (address 0, sampled at the first character of each
// string) and the result mode (address 4, read at the last character); write them only
// while idle. When the receiver stalls, the output and result registers hold and the
// four-word queue fills, after which in_stall rises. Synchronous reset clears the queue,
// the parse state and both valid flags, and restores radix 10 and signed 64-bit mode.
`default_nettype none

module text_to_integer_parser import ttip_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_text_char,
  input  wire logic        in_is_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_value_bits,
  output logic [15:0]      out_chars_consumed,
  output logic [1:0]       out_status,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [5:0] base_r;
  logic [1:0] mode_r;
  logic       wr_en;
  item_t      front_item, head_item;
  logic       q_full, head_valid, pop, fin_ready, fin_push;
  fin_t       fin;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_DEC;
      mode_r <= MODE_S64;
    end else if (wr_en) begin
      if (paddr[2:2] == REG_BASE) begin
        base_r <= pwdata[5:0];
      end else begin
        mode_r <= pwdata[1:0];
      end
    end
  end

  always_comb begin
    unique case (paddr[2:2])
      REG_BASE: prdata = {26'd0, base_r};
      REG_MODE: prdata = {30'd0, mode_r};
      default:  prdata = '0;
    endcase
  end

  assign in_stall = q_full;

  ttip_front u_front (
    .text_char (in_text_char),
    .is_last   (in_is_last),
    .item      (front_item)
  );

  ttip_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_valid && !q_full),
    .push_item  (front_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  ttip_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_base   (base_r),
    .cfg_mode   (mode_r),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .fin_ready  (fin_ready),
    .fin_push   (fin_push),
    .fin        (fin)
  );

  ttip_result u_result (
    .clk                (clk),
    .rst_n              (rst_n),
    .fin_push           (fin_push),
    .fin                (fin),
    .fin_ready          (fin_ready),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_value_bits     (out_value_bits),
    .out_chars_consumed (out_chars_consumed),
    .out_status         (out_status)
  );

endmodule

`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for text_to_integer_parser: streams strings one character per
// word, predicts each conversion in step with the design and checks every result word.
// Depends on ttip_pkg and the RTL of the block.

module testbench import ttip_pkg::*; ();

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } text_word_t;

  typedef struct {
    logic [63:0] value;
    logic [15:0] consumed;
    status_t     status;
  } conv_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_text_char = 8'd0;
  logic        in_is_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_value_bits;
  logic [15:0] out_chars_consumed;
  logic [1:0]  out_status;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  text_word_t chars_to_send[$];
  text_word_t next_word;
  conv_t      expected_conversions[$];
  conv_t      want;
  int         chars_queued = 0;
  int         chars_taken = 0;
  int         results_seen = 0;
  int         mismatches = 0;
  int         send_gap_pct = 0;
  int         recv_stall_pct = 0;

  logic [63:0] range_edges [0:6] = '{64'h7FFF_FFFF, 64'h8000_0000, 64'hFFFF_FFFF,
                                      64'h1_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                                      64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF};

  // Shadow copy of the registers and the parse state of the current string.
  logic [5:0]  cfg_radix = BASE_DEC;
  logic [1:0]  cfg_mode = MODE_S64;
  phase_t      parse_state = PH_SPACE;
  logic [63:0] acc = 64'd0;
  logic        neg = 1'b0;
  logic [5:0]  radix_now = 6'd0;
  logic [15:0] pos = 16'd0;
  logic [15:0] end_pos = 16'd0;
  logic        zero_pfx = 1'b0;
  logic        ovf = 1'b0;
  logic        got_digit = 1'b0;

  text_to_integer_parser uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_text_char(in_text_char), .in_is_last(in_is_last),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_value_bits(out_value_bits), .out_chars_consumed(out_chars_consumed),
    .out_status(out_status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  function automatic logic [5:0] digit_of(logic [7:0] c);
    logic [7:0] t;
    t = 8'd36;
    if (c >= CH_D0 && c <= CH_D9) t = c - CH_D0;
    else if (c >= CH_LA && c <= CH_LZ) t = c - CH_LA + 8'd10;
    else if (c >= CH_UA && c <= CH_UZ) t = c - CH_UA + 8'd10;
    return t[5:0];
  endfunction

  function automatic void accept_digit(logic [5:0] d, logic [15:0] nxt);
    logic [63:0] lim;
    if (!ovf) begin
      lim = (64'hFFFF_FFFF_FFFF_FFFF - {58'd0, d}) / {58'd0, radix_now};
      if (acc > lim) begin
        ovf = 1'b1;
        acc = 64'hFFFF_FFFF_FFFF_FFFF;
      end else begin
        acc = acc * {58'd0, radix_now} + {58'd0, d};
      end
    end
    got_digit = 1'b1;
    end_pos = nxt;
    parse_state = PH_DIGITS;
  endfunction

  function automatic void try_digit(logic [7:0] c, logic [5:0] fallback, logic [15:0] nxt);
    logic [5:0] d;
    if (radix_now == BASE_AUTO) radix_now = fallback;
    d = digit_of(c);
    if (d < radix_now) accept_digit(d, nxt);
    else parse_state = PH_DONE;
  endfunction

  function automatic void start_number(logic [7:0] c, logic [15:0] nxt);
    if (c == CH_D0 && (radix_now == BASE_AUTO || radix_now == BASE_OCT ||
                       radix_now == BASE_HEX)) begin
      zero_pfx = 1'b1;
      got_digit = 1'b1;
      acc = 64'd0;
      end_pos = nxt;
      parse_state = PH_ZERO;
    end else begin
      try_digit(c, BASE_DEC, nxt);
    end
  endfunction

  function automatic conv_t convert_string();
    conv_t r;
    logic [63:0] lim;
    r = '{64'd0, 16'd0, ST_OK};
    if (parse_state == PH_BADBASE) begin
      r.status = ST_BADBASE;
    end else if (!got_digit) begin
      r.status = ST_NODIG;
    end else begin
      r.consumed = end_pos;
      if (cfg_mode == MODE_S32 || cfg_mode == MODE_S64) begin
        lim = (cfg_mode == MODE_S32) ? 64'h7FFF_FFFF : 64'h7FFF_FFFF_FFFF_FFFF;
        if (!neg) begin
          if (!ovf && acc <= lim) begin
            r.value = acc;
          end else begin
            r.value = lim;
            r.status = ST_RANGE;
          end
        end else if (!ovf && acc <= lim + 64'd1) begin
          r.value = 64'd0 - acc;
        end else begin
          r.value = 64'd0 - (lim + 64'd1);
          r.status = ST_RANGE;
        end
      end else begin
        lim = (cfg_mode == MODE_U32) ? 64'hFFFF_FFFF : 64'hFFFF_FFFF_FFFF_FFFF;
        if (ovf || acc > lim) begin
          r.value = lim;
          r.status = ST_RANGE;
        end else begin
          r.value = (neg ? 64'd0 - acc : acc) & lim;
        end
      end
    end
    return r;
  endfunction

  function automatic void predict_char(logic [7:0] c, logic close);
    logic [15:0] nxt;
    nxt = (pos < CNT_LIMIT) ? pos + 16'd1 : CNT_LIMIT;
    if (pos == 16'd0) begin
      radix_now = cfg_radix;
      if (radix_now == BASE_ONE || radix_now > BASE_MAX) parse_state = PH_BADBASE;
    end
    case (parse_state)
      PH_SPACE: begin
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
          parse_state = PH_SPACE;
        end else if (c == CH_MINUS || c == CH_PLUS) begin
          neg = (c == CH_MINUS);
          parse_state = PH_SIGN;
        end else begin
          start_number(c, nxt);
        end
      end
      PH_SIGN: start_number(c, nxt);
      PH_ZERO: begin
        if ((radix_now == BASE_AUTO || radix_now == BASE_HEX) && (c == "x" || c == "X")) begin
          radix_now = BASE_HEX;
          parse_state = PH_HEXPFX;
        end else begin
          try_digit(c, BASE_OCT, nxt);
        end
      end
      PH_HEXPFX, PH_DIGITS: try_digit(c, BASE_DEC, nxt);
      default: ;
    endcase
    pos = nxt;
    if (close) begin
      expected_conversions.push_back(convert_string());
      parse_state = PH_SPACE;
      acc = 64'd0;
      neg = 1'b0;
      radix_now = 6'd0;
      pos = 16'd0;
      end_pos = 16'd0;
      zero_pfx = 1'b0;
      ovf = 1'b0;
      got_digit = 1'b0;
    end
  endfunction

  function automatic void push_char(logic [7:0] c, logic close);
    text_word_t w;
    w.ch = c;
    w.last = close;
    chars_to_send.push_back(w);
    chars_queued++;
  endfunction

  function automatic void queue_text(string s, logic close);
    for (int i = 0; i < s.len(); i++) push_char(s[i], close && i == s.len() - 1);
  endfunction

  function automatic void queue_random_text(logic [5:0] radix);
    logic [7:0]  txt[$];
    logic [7:0]  digs[$];
    logic [63:0] v;
    logic [5:0]  r;
    logic [7:0]  b;
    int          kind;
    int          n;
    kind = $urandom_range(19);
    r = (radix == BASE_AUTO || radix == BASE_ONE || radix > BASE_MAX) ? BASE_DEC : radix;
    if (kind < 2) begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        b = 8'($urandom);
        txt.push_back(b);
      end
    end else begin
      n = $urandom_range(5);
      if (n < 3) begin
        repeat (n) begin
          b = 8'($urandom_range(9, 14));
          txt.push_back(b == 8'd14 ? CH_SPACE : b);
        end
      end
      n = $urandom_range(3);
      if (n == 0) txt.push_back(CH_MINUS);
      else if (n == 1) txt.push_back(CH_PLUS);
      if ((radix == BASE_AUTO || radix == BASE_HEX) && $urandom_range(2) == 0) begin
        txt.push_back(CH_D0);
        txt.push_back($urandom_range(1) ? "x" : "X");
        r = BASE_HEX;
      end else if ((radix == BASE_AUTO || radix == BASE_OCT) && $urandom_range(3) == 0) begin
        txt.push_back(CH_D0);
        r = BASE_OCT;
      end
      if (kind == 2) begin
        b = 8'($urandom);
        txt.push_back(b);
      end else begin
        if (kind < 7) begin
          v = range_edges[$urandom_range(6)];
          n = $urandom_range(2);
          if (n == 0) v = v - 64'd1;
          else if (n == 2) v = v + 64'd1;
          if (v == 64'd0) digs.push_back(8'd0);
          while (v != 64'd0) begin
            digs.push_front(8'(v % {58'd0, r}));
            v = v / {58'd0, r};
          end
        end else begin
          n = (kind < 9) ? $urandom_range(15, 25) : $urandom_range(1, 8);
          repeat (n) digs.push_back(8'($urandom_range(int'(r) - 1)));
        end
        foreach (digs[i]) begin
          if (digs[i] < 8'd10) txt.push_back(CH_D0 + digs[i]);
          else txt.push_back(($urandom_range(1) ? CH_LA : CH_UA) + digs[i] - 8'd10);
        end
        if ($urandom_range(1)) begin
          b = 8'($urandom);
          txt.push_back(b);
        end
      end
    end
    foreach (txt[i]) push_char(txt[i], i == txt.size() - 1);
  endfunction

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_BASE) cfg_radix = val[5:0];
    else cfg_mode = val[1:0];
  endtask

  task automatic set_config(logic [5:0] radix, logic [1:0] mode);
    write_reg(REG_BASE, {26'd0, radix});
    write_reg(REG_MODE, {30'd0, mode});
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (chars_taken != chars_queued || expected_conversions.size() != 0);
    repeat (12) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_char(in_text_char, in_is_last);
        chars_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (chars_to_send.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
          next_word = chars_to_send.pop_front();
          in_text_char <= next_word.ch;
          in_is_last <= next_word.last;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_conversions.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word: value %h consumed %0d status %0d",
                     out_value_bits, out_chars_consumed, out_status);
        end else begin
          want = expected_conversions.pop_front();
          if (out_value_bits !== want.value || out_chars_consumed !== want.consumed ||
              out_status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result word %0d: expected value %h consumed %0d status %0d, got %h %0d %0d",
                       results_seen, want.value, want.consumed, want.status,
                       out_value_bits, out_chars_consumed, out_status);
          end
        end
        results_seen++;
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    #5_000_000;
    $display("text_to_integer_parser: mismatch");
    $finish;
  end

  initial begin
    logic [5:0]  radix;
    logic [5:0]  radix_plan [0:7];
    int          phase_start;
    radix_plan = '{6'd63, 6'd37, BASE_AUTO, BASE_OCT, BASE_HEX, 6'd2, BASE_MAX, BASE_DEC};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    send_gap_pct = 15;
    recv_stall_pct = 68;

    // Reset values of the registers: radix 10, signed 64-bit.
    queue_text("\t-42", 1'b1);
    queue_text("+z", 1'b1);
    push_char(8'h00, 1'b1);
    push_char("7", 1'b0);
    push_char(8'hFF, 1'b1);
    wait_idle();
    set_config(BASE_AUTO, MODE_U32);
    queue_text("0x1F", 1'b1);
    queue_text("0xg", 1'b1);
    queue_text("-1", 1'b1);
    wait_idle();
    set_config(BASE_MAX, MODE_S32);
    queue_text("zzzzzzzzzzzzz", 1'b1);
    wait_idle();
    set_config(BASE_ONE, MODE_U64);
    queue_text("5", 1'b1);
    wait_idle();
    // The radix is held from the first character, the mode is taken at the last.
    set_config(BASE_HEX, MODE_U64);
    queue_text("-ff", 1'b0);
    wait_idle();
    set_config(6'd2, MODE_S32);
    queue_text("1", 1'b1);
    queue_text("101", 1'b1);
    wait_idle();

    for (int p = 0; p < 15; p++) begin
      if (p < 5) begin
        send_gap_pct = 15;
        recv_stall_pct = 68;
      end else if (p < 10) begin
        send_gap_pct = 68;
        recv_stall_pct = 15;
      end else begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
      if (p < 8) begin
        radix = radix_plan[p];
      end else begin
        case ($urandom_range(9))
          0, 1: radix = BASE_AUTO;
          2: radix = BASE_HEX;
          3: radix = BASE_OCT;
          4: radix = BASE_DEC;
          5: radix = 6'($urandom_range(37, 63));
          default: radix = 6'($urandom_range(2, 36));
        endcase
      end
      set_config(radix, 2'($urandom_range(3)));
      phase_start = chars_queued;
      while (chars_queued - phase_start < 100) queue_random_text(radix);
      wait_idle();
    end

    if (mismatches == 0 && expected_conversions.size() == 0) begin
      $display("text_to_integer_parser: match");
    end else begin
      $display("text_to_integer_parser: mismatch");
    end
    $finish;
  end

endmodule
